// ===== rtl/core/utf8_codepoint_decoder_unit_assert.svh =====
// Assertion macros for the UTF-8 code point decoder.
// Used by utf8_codepoint_decoder_unit; no other dependencies.
`ifndef UTF8_CODEPOINT_DECODER_UNIT_ASSERT_SVH
`define UTF8_CODEPOINT_DECODER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// property checked only out of reset
`define UTF8CD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property checked on every edge, reset included
`define UTF8CD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UTF8CD_ASSERT(lbl, clk, rst_n, prop, msg)
`define UTF8CD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/core/utf8cd_pkg.sv =====
// Shared types and constants of the UTF-8 code point decoder.
// No dependencies.
package utf8cd_pkg;

  localparam int unsigned CpW = 21;

  // byte class masks and codes
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContCode  = 8'h80;
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Code = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Code = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Code = 8'hF0;

  localparam logic [2:0] SeqLen2 = 3'd2;
  localparam logic [2:0] SeqLen3 = 3'd3;
  localparam logic [2:0] SeqLen4 = 3'd4;

  localparam logic [1:0] PendNone = 2'd0;
  localparam logic [1:0] PendOne  = 2'd1;
  localparam logic [1:0] PendFull = 2'd3;

  localparam logic [CpW-1:0] SubstCp = 21'd63;

  // open sequence: lead, buffered continuations, fill and length
  typedef struct packed {
    logic [7:0] lead;
    logic [7:0] cont1;
    logic [7:0] cont2;
    logic [1:0] count;
    logic [2:0] len;
  } seq_state_t;

  localparam seq_state_t SeqIdle = '0;

  // words one byte produces: cnt-1 substitutes, then the final word
  typedef struct packed {
    logic [2:0]     cnt;
    logic [CpW-1:0] cp;
    logic           sub;
    logic           last;
  } dec_res_t;

endpackage

// ===== rtl/core/utf8cd_if.sv =====
// Valid/ready channels of the UTF-8 code point decoder: text bytes in,
// code points out. Depends on utf8cd_pkg.
interface utf8cd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface utf8cd_cp_if import utf8cd_pkg::*; ;
  logic           valid;
  logic           ready;
  logic [CpW-1:0] code_point;
  logic           substituted;
  logic           last_of_text;

  modport source (output valid, output code_point, output substituted,
                  output last_of_text, input ready);
  modport sink   (input valid, input code_point, input substituted,
                  input last_of_text, output ready);
endinterface

// ===== rtl/core/utf8cd_decode.sv =====
// Single-byte decode step: next sequence state and the words one byte yields.
// Depends on utf8cd_pkg.
module utf8cd_decode import utf8cd_pkg::*; (
  input  seq_state_t st_i,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  output seq_state_t st_o,
  output dec_res_t   res_o
);

  logic           is_cont;
  logic           done;
  logic [CpW-1:0] cp_asm;

  assign is_cont = (text_byte_i & ContMask) == ContCode;

  always_comb begin
    unique case (st_i.len)
      SeqLen2: cp_asm = {10'd0, st_i.lead[4:0], text_byte_i[5:0]};
      SeqLen3: cp_asm = {5'd0, st_i.lead[3:0], st_i.cont1[5:0], text_byte_i[5:0]};
      default: cp_asm = {st_i.lead[2:0], st_i.cont1[5:0], st_i.cont2[5:0],
                         text_byte_i[5:0]};
    endcase
  end

  always_comb begin
    st_o       = st_i;
    res_o.cnt  = 3'd0;
    res_o.cp   = '0;
    res_o.sub  = 1'b0;
    res_o.last = end_of_text_i;
    done       = 1'b0;

    if (st_i.count != PendNone) begin
      if (is_cont) begin
        done = 1'b1;
        if ({1'b0, st_i.count} + 3'd1 == st_i.len) begin
          st_o      = SeqIdle;
          res_o.cnt = 3'd1;
          res_o.cp  = cp_asm;
        end else if (st_i.count != PendFull) begin
          if (st_i.count == PendOne) begin
            st_o.cont1 = text_byte_i;
          end else begin
            st_o.cont2 = text_byte_i;
          end
          st_o.count = st_i.count + 2'd1;
        end else begin
          // buffer full and still not complete: flush plus this byte
          st_o      = SeqIdle;
          res_o.cnt = {1'b0, st_i.count} + 3'd1;
          res_o.cp  = SubstCp;
          res_o.sub = 1'b1;
        end
      end else begin
        // broken sequence: one substitute per buffered byte
        st_o      = SeqIdle;
        res_o.cnt = {1'b0, st_i.count};
        res_o.cp  = SubstCp;
        res_o.sub = 1'b1;
      end
    end

    if (!done) begin
      if (!text_byte_i[7]) begin
        res_o.cnt = res_o.cnt + 3'd1;
        res_o.cp  = {13'd0, text_byte_i};
        res_o.sub = 1'b0;
      end else if ((text_byte_i & Lead2Mask) == Lead2Code) begin
        st_o.lead  = text_byte_i;
        st_o.count = PendOne;
        st_o.len   = SeqLen2;
      end else if ((text_byte_i & Lead3Mask) == Lead3Code) begin
        st_o.lead  = text_byte_i;
        st_o.count = PendOne;
        st_o.len   = SeqLen3;
      end else if ((text_byte_i & Lead4Mask) == Lead4Code) begin
        st_o.lead  = text_byte_i;
        st_o.count = PendOne;
        st_o.len   = SeqLen4;
      end else begin
        res_o.cnt = res_o.cnt + 3'd1;
        res_o.cp  = SubstCp;
        res_o.sub = 1'b1;
      end
    end

    // end of text flushes whatever is still open
    if (end_of_text_i && (st_o.count != PendNone)) begin
      res_o.cnt = res_o.cnt + {1'b0, st_o.count};
      res_o.cp  = SubstCp;
      res_o.sub = 1'b1;
      st_o      = SeqIdle;
    end
  end

endmodule

// ===== rtl/core/utf8_codepoint_decoder_unit.sv =====
// Channel   Dir  Word
// byte_i    in   text_byte[7:0], end_of_text
// cp_o      out  code_point[20:0], substituted, last_of_text
//
// One byte per cycle while each byte yields at most one code point and cp_o
// is ready; a byte that yields k code points (up to 4) holds the next byte
// until the single output word register has sent all k, one per ready cycle.
// Path: input register, then decode into the output register.
// rst_ni clears the open sequence and both valid stages.
// A stalled output keeps the next byte parked in the input register.
//
// Top level of the UTF-8 code point decoder.
// Depends on utf8cd_pkg, utf8cd_if, utf8cd_decode and the assertion header.
`include "utf8_codepoint_decoder_unit_assert.svh"

module utf8_codepoint_decoder_unit import utf8cd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  utf8cd_byte_if.sink byte_i,
  utf8cd_cp_if.source cp_o
);

  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       end_q;

  seq_state_t st_q, st_d;
  dec_res_t   res;

  logic [2:0]     rem_q, rem_d;
  logic [CpW-1:0] last_cp_q;
  logic           last_sub_q;
  logic           last_end_q;

  logic load;
  logic out_fire;

  assign out_fire     = cp_o.valid && cp_o.ready;
  assign load         = in_vld_q && ((rem_q == 3'd0) || ((rem_q == 3'd1) && cp_o.ready));
  assign byte_i.ready = !in_vld_q || load;

  utf8cd_decode u_decode (
    .st_i          (st_q),
    .text_byte_i   (byte_q),
    .end_of_text_i (end_q),
    .st_o          (st_d),
    .res_o         (res)
  );

  always_comb begin
    rem_d = rem_q;
    if (load) begin
      rem_d = res.cnt;
    end else if (out_fire) begin
      rem_d = rem_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      st_q     <= SeqIdle;
      rem_q    <= 3'd0;
    end else begin
      if (byte_i.valid && byte_i.ready) begin
        in_vld_q <= 1'b1;
      end else if (load) begin
        in_vld_q <= 1'b0;
      end
      if (load) begin
        st_q <= st_d;
      end
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      byte_q <= byte_i.text_byte;
      end_q  <= byte_i.end_of_text;
    end
    if (load) begin
      last_cp_q  <= res.cp;
      last_sub_q <= res.sub;
      last_end_q <= res.last;
    end
  end

  // leading words of a group are substitutes; the final word carries the rest
  assign cp_o.valid        = rem_q != 3'd0;
  assign cp_o.code_point   = (rem_q == 3'd1) ? last_cp_q : SubstCp;
  assign cp_o.substituted  = (rem_q == 3'd1) ? last_sub_q : 1'b1;
  assign cp_o.last_of_text = (rem_q == 3'd1) && last_end_q;

  `UTF8CD_ASSERT_ALWAYS(a_rem_range, clk_i, rem_q <= 3'd4, "word count out of range")
  `UTF8CD_ASSERT(a_seq_open, clk_i, rst_ni, (st_q.count != PendNone) |-> (st_q.len > {1'b0, st_q.count}), "open sequence already complete")
  `UTF8CD_ASSERT(a_stall_hold, clk_i, rst_ni, (cp_o.valid && !cp_o.ready) |=> (rem_q == $past(rem_q)), "word count moved during stall")
  `UTF8CD_ASSERT(a_last_final, clk_i, rst_ni, cp_o.last_of_text |-> (rem_q == 3'd1), "end flag on a non-final word")

endmodule
